/* hw/rtl/lppd_pkg.sv */
// ----------------------------------------------------------------------------
// lppd_pkg: shared types and constants
// Codes, start bytes, parser phases and the config/result structs used by the
// length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned CNT_W  = 16;

	// start codes
	localparam logic [BYTE_W-1:0] SOF_SHORT_A = 8'hC1;
	localparam logic [BYTE_W-1:0] SOF_LONG_A  = 8'hC2;
	localparam logic [BYTE_W-1:0] SOF_SHORT_B = 8'hC3;
	localparam logic [BYTE_W-1:0] SOF_LONG_B  = 8'hC4;

	localparam logic [LEN_W-1:0] HDR_LEN_SHORT = 16'd2;
	localparam logic [LEN_W-1:0] HDR_LEN_LONG  = 16'd3;
	localparam logic [CNT_W-1:0] CNT_MAX       = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_TICK    = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_HEADER = 3'd1,
		ST_SIZE   = 3'd2,
		ST_FLOOD  = 3'd3,
		ST_HALTED = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_LEN1  = 4'b0010,
		PH_LEN2  = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

	// configuration register indexes
	localparam logic CFG_MAX_FRAMES  = 1'b0;
	localparam logic CFG_FLOOD_EXEMPT = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0] max_frames_per_second;
		logic             flood_exempt;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_out;
		logic              in_frame;
		logic              frame_first;
		logic              frame_last;
		status_t           status;
	} result_t;

endpackage

/* hw/rtl/length_prefixed_packet_deframer_core.sv */
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core: byte stream to frame deframer
// Cuts received bytes into length-prefixed frames with first/last marks,
// header, size and flood checks, and a halt-until-restart error policy.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A beat is taken every cycle when the output
// side keeps up; each beat passes the input register, then the result
// register. The parse state and frame counter are updated by a single pass
// of compare/count logic between the two registers, so back-to-back beats
// see each other's state with no bubble. Input tuser carries the operation
// (byte, tick, restart); the byte itself is in tdata. Every accepted beat
// yields exactly one output beat, including ticks and restarts (data 0).
// Start codes C1/C3 take a one-byte length, C2/C4 a two-byte big-endian
// length; the length counts the header. Any header, size or flood error
// halts the block until a restart beat. Configuration (flood limit, exempt
// flag) may be written only while no beat is in flight.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_core
	import lppd_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] operation
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] byte_out
	output logic        m_axis_tlast,   // frame_last
	output logic [4:0]  m_axis_tuser,   // [0] in_frame, [1] frame_first, [4:2] status
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// input register
	logic              v_s1;
	op_t               op_s1;
	logic [BYTE_W-1:0] byte_s1;

	// result register
	logic              v_s2;
	result_t           res_s2;

	cfg_t              cfg_q;
	result_t           res;
	logic              advance;
	logic              step;

	// result slot is free or draining this cycle
	assign advance       = !v_s2 || m_axis_tready;
	assign step          = v_s1 && advance;
	assign s_axis_tready = !v_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_frames_per_second <= CNT_MAX;
			cfg_q.flood_exempt          <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_FRAMES:   cfg_q.max_frames_per_second <= cfg_data;
				CFG_FLOOD_EXEMPT: cfg_q.flood_exempt          <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// stage 1: capture the incoming beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= op_t'(s_axis_tuser);
			byte_s1 <= s_axis_tdata;
		end
	end

	lppd_parser #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.op        (op_s1),
		.data_byte (byte_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	// stage 2: hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = res_s2.byte_out;
	assign m_axis_tlast  = res_s2.frame_last;
	assign m_axis_tuser  = {res_s2.status, res_s2.frame_first, res_s2.in_frame};

endmodule

/* hw/rtl/lppd_parser.sv */
// ----------------------------------------------------------------------------
// lppd_parser: frame parser and flood counter
// Holds the parse state, frame count and halt flag; computes one result per
// step and updates its state on the same edge.
// ----------------------------------------------------------------------------
module lppd_parser
	import lppd_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 8192
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  op_t               op,
	input  logic [BYTE_W-1:0] data_byte,
	input  cfg_t              cfg,
	output result_t           res
);

	localparam logic [LEN_W-1:0] BUF_LIM = LEN_W'(BUFFER_BYTES);

	phase_t            phase_q, phase_d;
	logic              long_q, long_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  seen_q, seen_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              halted_q, halted_d;

	logic [CNT_W-1:0]  close_cnt;
	logic              flood;
	logic [LEN_W-1:0]  len_short;
	logic [LEN_W-1:0]  len_long;
	logic              short_bad;
	logic              long_bad;
	logic [LEN_W-1:0]  seen_inc;
	logic              is_sof;
	logic              is_long_sof;

	// saturating count of the frame being closed
	assign close_cnt = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);
	assign flood     = !cfg.flood_exempt && (close_cnt >= cfg.max_frames_per_second);

	assign len_short = {{(LEN_W-BYTE_W){1'b0}}, data_byte};
	assign len_long  = {len_q[LEN_W-1:BYTE_W], data_byte};
	assign short_bad = (len_short == '0) || (len_short < HDR_LEN_SHORT) ||
		(len_short > BUF_LIM);
	assign long_bad  = (len_long == '0) || (len_long < HDR_LEN_LONG) ||
		(len_long > BUF_LIM);
	assign seen_inc  = seen_q + LEN_W'(1);

	assign is_long_sof = (data_byte == SOF_LONG_A) || (data_byte == SOF_LONG_B);
	assign is_sof      = is_long_sof || (data_byte == SOF_SHORT_A) ||
		(data_byte == SOF_SHORT_B);

	always_comb begin
		res          = '0;
		res.status   = ST_OK;
		phase_d      = phase_q;
		long_d       = long_q;
		len_d        = len_q;
		seen_d       = seen_q;
		count_d      = count_q;
		halted_d     = halted_q;
		if (step) begin
			case (op)
				OP_TICK: begin
					count_d    = '0;
					res.status = halted_q ? ST_HALTED : ST_OK;
				end
				OP_RESTART: begin
					phase_d  = PH_START;
					long_d   = 1'b0;
					len_d    = '0;
					seen_d   = '0;
					count_d  = '0;
					halted_d = 1'b0;
				end
				OP_BYTE: begin
					if (halted_q) begin
						res.status = ST_HALTED;
					end else begin
						res.byte_out = data_byte;
						case (phase_q)
							PH_START: begin
								if (is_sof) begin
									long_d          = is_long_sof;
									seen_d          = LEN_W'(1);
									len_d           = '0;
									phase_d         = PH_LEN1;
									res.in_frame    = 1'b1;
									res.frame_first = 1'b1;
								end else begin
									res.status = ST_HEADER;
									halted_d   = 1'b1;
								end
							end
							PH_LEN1: begin
								res.in_frame = 1'b1;
								seen_d       = LEN_W'(2);
								if (long_q) begin
									len_d   = {data_byte, {(LEN_W-BYTE_W){1'b0}}};
									phase_d = PH_LEN2;
								end else begin
									len_d = len_short;
									if (short_bad) begin
										res.status = ST_SIZE;
										halted_d   = 1'b1;
									end else if (len_short == HDR_LEN_SHORT) begin
										res.frame_last = 1'b1;
									end else begin
										phase_d = PH_BODY;
									end
								end
							end
							PH_LEN2: begin
								res.in_frame = 1'b1;
								seen_d       = LEN_W'(3);
								len_d        = len_long;
								if (long_bad) begin
									res.status = ST_SIZE;
									halted_d   = 1'b1;
								end else if (len_long == HDR_LEN_LONG) begin
									res.frame_last = 1'b1;
								end else begin
									phase_d = PH_BODY;
								end
							end
							default: begin
								res.in_frame = 1'b1;
								seen_d       = seen_inc;
								if (seen_inc >= len_q) begin
									res.frame_last = 1'b1;
								end
							end
						endcase
						// frame complete: reset parser, count it, check flood
						if (res.frame_last) begin
							phase_d = PH_START;
							long_d  = 1'b0;
							len_d   = '0;
							seen_d  = '0;
							count_d = close_cnt;
							if (flood) begin
								halted_d   = 1'b1;
								res.status = ST_FLOOD;
							end
						end
					end
				end
				default: begin
					res.status = halted_q ? ST_HALTED : ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			long_q   <= 1'b0;
			len_q    <= '0;
			seen_q   <= '0;
			count_q  <= '0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			long_q   <= long_d;
			len_q    <= len_d;
			seen_q   <= seen_d;
			count_q  <= count_d;
			halted_q <= halted_d;
		end
	end

`ifndef SYNTHESIS
	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		step && (res.status == ST_HEADER || res.status == ST_SIZE ||
		res.status == ST_FLOOD) |=> halted_q)
		else $error("error status without halt");

	a_halted_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		step && halted_q && op == OP_BYTE |->
		res.status == ST_HALTED && !res.in_frame && res.byte_out == '0)
		else $error("byte processed while halted");

	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.frame_last |=> phase_q == PH_START && seen_q == '0)
		else $error("parser not rearmed after frame end");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && op == OP_RESTART |=> !halted_q && count_q == '0)
		else $error("restart did not clear state");
`endif

endmodule
